// ===== src/bounded_set_table_defines.svh =====
// assertion macros for the bounded set table checker
`ifndef BOUNDED_SET_TABLE_DEFINES_SVH
`define BOUNDED_SET_TABLE_DEFINES_SVH

// property checked out of reset only
`define BST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define BST_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/bst_pkg.sv =====
// shared constants, operation codes and control structs of the bounded set table
package bst_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int VALUE_W_DEF = 32;
    localparam int VALUE_IN_W  = 32;
    localparam int KIND_W      = 2;
    localparam int CAP_W       = 5;
    localparam int COUNT_W     = 5;
    localparam int OUT_DATA_W  = 8;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TEST   = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } bst_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic scan_done;
    } bst_sts_t;

endpackage

// ===== src/bst_datapath.sv =====
// entry store, scan compare, fill count, capacity register and result register
module bst_datapath #(
    parameter int DEPTH       = bst_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = bst_pkg::VALUE_W_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bst_pkg::bst_cmd_t              cmd,
    output bst_pkg::bst_sts_t              sts,
    input  logic [bst_pkg::KIND_W-1:0]     in_kind,
    input  logic [bst_pkg::VALUE_IN_W-1:0] in_value,
    input  logic                           cfg_we,
    input  logic [bst_pkg::CAP_W-1:0]      cfg_data,
    output logic                           out_ok,
    output logic [bst_pkg::COUNT_W-1:0]    out_count
);
    import bst_pkg::*;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;

    logic [VALUE_WIDTH-1:0] mem [DEPTH];
    logic [VALUE_WIDTH-1:0] rd_data_reg;

    logic [KIND_W-1:0]      kind_reg, kind_next;
    logic [VALUE_WIDTH-1:0] key_reg, key_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [CAP_W-1:0]       cap_reg, cap_next;
    logic [FILL_W-1:0]      ptr_reg, ptr_next;
    logic                   pend_reg, pend_next;
    logic [FILL_W-1:0]      pend_idx_reg, pend_idx_next;
    logic                   found_reg, found_next;
    logic [ADDR_W-1:0]      slot_reg, slot_next;
    logic [VALUE_WIDTH-1:0] last_reg, last_next;
    logic                   ok_reg, ok_next;
    logic [COUNT_W-1:0]     count_reg, count_next;

    logic                   issue;
    logic                   hit;
    logic                   is_last;
    logic                   we;
    logic [ADDR_W-1:0]      wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic [CMP_W-1:0]       cap_x;
    logic [CMP_W-1:0]       depth_x;
    logic [CMP_W-1:0]       eff_cap;
    logic [CMP_W-1:0]       fill_x;

    // scan: one read issued per cycle, compared in the cycle after
    assign issue   = cmd.scan && (ptr_reg < fill_reg);
    assign hit     = pend_reg && (rd_data_reg == key_reg);
    assign is_last = pend_reg && (pend_idx_reg == (fill_reg - FILL_W'(1)));
    assign sts.scan_done = !issue && !pend_reg;

    // capacity saturates at the store depth
    assign cap_x   = CMP_W'(cap_reg);
    assign depth_x = CMP_W'(DEPTH);
    assign eff_cap = (cap_x > depth_x) ? depth_x : cap_x;
    assign fill_x  = CMP_W'(fill_reg);

    // next-state logic
    always_comb
    begin
        kind_next     = kind_reg;
        key_next      = key_reg;
        fill_next     = fill_reg;
        cap_next      = cap_reg;
        ptr_next      = ptr_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        found_next    = found_reg;
        slot_next     = slot_reg;
        last_next     = last_reg;
        ok_next       = ok_reg;
        count_next    = count_reg;
        we            = 1'b0;
        wr_addr       = slot_reg;
        wr_data       = last_reg;

        if (cfg_we)
        begin
            cap_next = cfg_data;
        end

        if (cmd.load)
        begin
            kind_next  = in_kind;
            key_next   = VALUE_WIDTH'(in_value);
            ptr_next   = '0;
            pend_next  = 1'b0;
            found_next = 1'b0;
        end

        if (cmd.scan)
        begin
            pend_next     = issue;
            pend_idx_next = ptr_reg;
            if (issue)
            begin
                ptr_next = ptr_reg + FILL_W'(1);
            end
            if (hit)
            begin
                found_next = 1'b1;
                slot_next  = ADDR_W'(pend_idx_reg);
            end
            if (is_last)
            begin
                last_next = rd_data_reg;
            end
        end

        if (cmd.commit)
        begin
            ok_next = 1'b0;
            case (kind_reg)
                KIND_ADD:
                begin
                    if (!found_reg && (fill_x < eff_cap))
                    begin
                        we        = 1'b1;
                        wr_addr   = ADDR_W'(fill_reg);
                        wr_data   = key_reg;
                        fill_next = fill_reg + FILL_W'(1);
                        ok_next   = 1'b1;
                    end
                end
                KIND_REMOVE:
                begin
                    // last entry moves into the freed slot
                    if (found_reg)
                    begin
                        we        = 1'b1;
                        wr_addr   = slot_reg;
                        wr_data   = last_reg;
                        fill_next = fill_reg - FILL_W'(1);
                        ok_next   = 1'b1;
                    end
                end
                KIND_TEST:
                begin
                    ok_next = found_reg;
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
            count_next = COUNT_W'(fill_next);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            cap_reg  <= CAP_RESET;
            ptr_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            cap_reg  <= cap_next;
            ptr_reg  <= ptr_next;
            pend_reg <= pend_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        key_reg      <= key_next;
        pend_idx_reg <= pend_idx_next;
        found_reg    <= found_next;
        slot_reg     <= slot_next;
        last_reg     <= last_next;
        ok_reg       <= ok_next;
        count_reg    <= count_next;
    end

    // entry store, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            rd_data_reg <= mem[ADDR_W'(ptr_reg)];
        end
    end

    assign out_ok    = ok_reg;
    assign out_count = count_reg;

endmodule

// ===== src/bst_ctrl.sv =====
// controller: accept, scan, commit sequencing and output word valid
module bst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output bst_pkg::bst_cmd_t cmd,
    input  bst_pkg::bst_sts_t sts
);
    import bst_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    // result register free or being emptied this cycle
    assign out_free = !out_valid_reg || m_tready;

    // state transitions and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output word valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ===== src/bounded_set_table.sv =====
// sequence: an accepted input word is loaded, scanned over the live entries, then committed
// one word in flight: a new input word is taken only after the last one commits; the scan
//   reads one entry per cycle through a registered read, and the commit waits for a free result register
// a stalled result word holds back the commit of the next word, not its acceptance
// reset (rst_n, async, active low): fill count 0, capacity 16, no word pending
// top level of the bounded set table
module bounded_set_table #(
    parameter int DEPTH       = bst_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = bst_pkg::VALUE_W_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bst_pkg::VALUE_IN_W-1:0]  s_tdata,   // [31:0] value
    input  logic [bst_pkg::KIND_W-1:0]      s_tuser,   // [1:0] kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bst_pkg::OUT_DATA_W-1:0]  m_tdata,   // [4:0] count, rest zero
    output logic                            m_tuser,   // [0] ok
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bst_pkg::CAP_W-1:0]       cfg_data   // capacity
);
    import bst_pkg::*;

    bst_cmd_t           cmd;
    bst_sts_t           sts;
    logic [COUNT_W-1:0] out_count;

    bst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    bst_datapath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_kind   (s_tuser),
        .in_value  (s_tdata),
        .cfg_we    (cfg_valid),
        .cfg_data  (cfg_data),
        .out_ok    (m_tuser),
        .out_count (out_count)
    );

    // capacity writes are always taken
    assign cfg_ready = 1'b1;
    assign m_tdata   = OUT_DATA_W'(out_count);

endmodule

// ===== src/bst_checker.sv =====
// port-level checker for the bounded set table, bound to the top level
`include "bounded_set_table_defines.svh"

module bst_checker #(
    parameter int DEPTH = bst_pkg::DEPTH_DEF
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [bst_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic                            m_tuser
);

    logic count_in_range;

    // count field within the store depth
    assign count_in_range = (DEPTH > 31) || (m_tdata[4:0] <= 5'(DEPTH));

    // a stalled result word holds
    property p_out_hold;
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser));
    endproperty

    // no result word shows while in reset
    `BST_ASSERT_ALWAYS(a_no_out_in_reset, !rst_n |-> (m_tvalid !== 1'b1), "result word valid during reset")

    // one word at a time: input closes right after an accept
    `BST_ASSERT(a_one_in_flight, (s_tvalid && s_tready) |=> !s_tready, "input open during work")

    // count never exceeds the store depth
    `BST_ASSERT(a_count_bound, m_tvalid |-> count_in_range, "count above depth")

    `BST_ASSERT(a_out_hold, p_out_hold, "stalled result changed")

endmodule

bind bounded_set_table bst_checker #(.DEPTH(DEPTH)) u_bst_checker (.*);

// ===== dv/bounded_set_table_test.sv =====
// self-checking testbench for the bounded set table: directed and random add, remove, lookup
`timescale 1ns / 100ps

module bounded_set_table_test;
    import bst_pkg::*;

    // kind code that the block must ignore
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int POOL_N = 20;
    localparam int PHASE_N = 8;
    localparam int PHASE_WORDS = 125;

    // reply fields as the block should send them
    typedef struct packed {
        logic               ok;
        logic [COUNT_W-1:0] count;
    } set_reply_t;

    // mirror of the set contents, predicts every reply and checks it
    class set_mirror;
        logic [VALUE_IN_W-1:0] held [DEPTH_DEF];
        int unsigned fill;
        int unsigned capacity;
        set_reply_t awaited_replies [$];
        int unsigned mismatches;
        int unsigned replies_checked;
        int unsigned peak_fill;
        int unsigned refused_adds;
        int unsigned kind_seen [4];

        function new();
            fill = 0;
            capacity = CAP_RESET;
            mismatches = 0;
            replies_checked = 0;
            peak_fill = 0;
            refused_adds = 0;
            foreach (kind_seen[i])
                kind_seen[i] = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] c);
            capacity = c;
        endfunction

        function int outstanding();
            return awaited_replies.size();
        endfunction

        // linear search over the live entries only
        function int slot_of(logic [VALUE_IN_W-1:0] v);
            for (int i = 0; i < int'(fill); i++)
                if (held[i] == v)
                    return i;
            return -1;
        endfunction

        function void note_request(logic [KIND_W-1:0] kind, logic [VALUE_IN_W-1:0] v);
            int slot;
            int unsigned limit;
            set_reply_t r;
            slot = slot_of(v);
            // capacity above the store depth saturates
            limit = (capacity > DEPTH_DEF) ? DEPTH_DEF : capacity;
            r.ok = 1'b0;
            case (kind)
                KIND_ADD:
                begin
                    if (slot < 0 && fill < limit)
                    begin
                        held[fill] = v;
                        fill++;
                        r.ok = 1'b1;
                    end
                    else
                        refused_adds++;
                end
                KIND_REMOVE:
                begin
                    // last entry fills the hole
                    if (slot >= 0)
                    begin
                        held[slot] = held[fill - 1];
                        fill--;
                        r.ok = 1'b1;
                    end
                end
                KIND_TEST:
                    r.ok = (slot >= 0);
                default:
                    r.ok = 1'b0;
            endcase
            r.count = COUNT_W'(fill);
            kind_seen[kind]++;
            if (fill > peak_fill)
                peak_fill = fill;
            awaited_replies.push_back(r);
        endfunction

        function void check_reply(logic ok_seen, logic [OUT_DATA_W-1:0] data_seen);
            set_reply_t r;
            logic [OUT_DATA_W-1:0] data_awaited;
            if (awaited_replies.size() == 0)
            begin
                mismatches++;
                $display("%0t: reply with nothing awaited, ok %0d data %0h",
                         $time, ok_seen, data_seen);
                return;
            end
            r = awaited_replies.pop_front();
            data_awaited = OUT_DATA_W'(r.count);
            replies_checked++;
            if (ok_seen !== r.ok)
            begin
                mismatches++;
                $display("%0t: ok expected %0d got %0d", $time, r.ok, ok_seen);
            end
            if (data_seen !== data_awaited)
            begin
                mismatches++;
                $display("%0t: count word expected %0h got %0h",
                         $time, data_awaited, data_seen);
            end
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [VALUE_IN_W-1:0]   s_tdata = '0;    // [31:0] value
    logic [KIND_W-1:0]       s_tuser = KIND_ADD;  // [1:0] kind
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_tdata;         // [4:0] count, rest zero
    logic                    m_tuser;         // [0] ok
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CAP_W-1:0]        cfg_data = '0;

    set_mirror               mirror = new();
    int                      idle_mode = 0;
    logic [VALUE_IN_W-1:0]   value_pool [POOL_N];

    bounded_set_table u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receiver stalls in the stall phases
    always @(negedge clk)
    begin
        case (idle_mode)
            2: m_tready <= ($urandom_range(99) >= 54);
            3: m_tready <= ($urandom_range(99) >= 11);
            default: m_tready <= 1'b1;
        endcase
    end

    // watch all three handshakes at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                mirror.set_capacity(cfg_data);
            if (s_tvalid && s_tready)
                mirror.note_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                mirror.check_reply(m_tuser, m_tdata);
        end
    end

    function automatic bit sender_gap();
        case (idle_mode)
            1: return ($urandom_range(99) < 54);
            3: return ($urandom_range(99) < 11);
            default: return 1'b0;
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(logic [KIND_W-1:0] kind, logic [VALUE_IN_W-1:0] v);
        while (sender_gap())
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= v;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // stop sending and wait for every reply
    task automatic drain_replies();
        s_tvalid <= 1'b0;
        while (mirror.outstanding() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] c);
        cfg_valid <= 1'b1;
        cfg_data  <= c;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [KIND_W-1:0] draw_kind();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40)
            return KIND_ADD;
        else if (r < 65)
            return KIND_REMOVE;
        else if (r < 92)
            return KIND_TEST;
        return KIND_UNUSED;
    endfunction

    // mostly values from a small pool so that hits and duplicates are common
    function automatic logic [VALUE_IN_W-1:0] draw_value();
        if ($urandom_range(99) < 85)
            return value_pool[$urandom_range(POOL_N - 1)];
        return $urandom();
    endfunction

    // run time limit
    initial
    begin
        #2000000;
        $display("timeout with %0d replies still awaited", mirror.outstanding());
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        int unsigned phase_caps [PHASE_N];
        phase_caps = '{31, 16, 0, 5, 1, 16, 12, 31};
        foreach (value_pool[i])
            value_pool[i] = $urandom();
        value_pool[0] = '0;
        value_pool[1] = '1;

        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty set, duplicates, extremes, ignored kind, hole refill
        send_request(KIND_TEST,   32'h0000_0000);
        send_request(KIND_REMOVE, 32'h0000_0005);
        send_request(KIND_ADD,    32'h0000_0000);
        send_request(KIND_ADD,    32'h0000_0000);
        send_request(KIND_ADD,    32'hFFFF_FFFF);
        send_request(KIND_TEST,   32'hFFFF_FFFF);
        send_request(KIND_UNUSED, 32'h0000_0000);
        send_request(KIND_REMOVE, 32'h0000_0000);
        send_request(KIND_TEST,   32'h0000_0000);
        send_request(KIND_TEST,   32'hFFFF_FFFF);
        send_request(KIND_ADD,    32'h8000_0000);
        send_request(KIND_ADD,    32'h0000_0001);
        send_request(KIND_ADD,    32'h5555_5555);
        send_request(KIND_ADD,    32'hAAAA_AAAA);
        send_request(KIND_REMOVE, 32'h0000_0001);
        send_request(KIND_TEST,   32'hAAAA_AAAA);
        send_request(KIND_REMOVE, 32'h0000_0001);
        send_request(KIND_UNUSED, 32'hFFFF_FFFF);
        drain_replies();

        // capacity below the fill count
        write_capacity(5'd2);
        send_request(KIND_ADD,    32'h1234_5678);
        send_request(KIND_TEST,   32'h5555_5555);
        send_request(KIND_REMOVE, 32'h8000_0000);
        send_request(KIND_REMOVE, 32'hAAAA_AAAA);
        send_request(KIND_ADD,    32'h1234_5678);

        // random phases, each with its own capacity and idle pattern
        for (int p = 0; p < PHASE_N; p++)
        begin
            drain_replies();
            write_capacity(CAP_W'(phase_caps[p]));
            idle_mode = p % 4;
            for (int k = 0; k < 4; k++)
                value_pool[2 + $urandom_range(POOL_N - 3)] = $urandom();
            for (int n = 0; n < PHASE_WORDS; n++)
                send_request(draw_kind(), draw_value());
        end
        drain_replies();
        repeat (4 * DEPTH_DEF) @(posedge clk);

        $display("covered %0d add, %0d remove, %0d lookup, %0d ignored-kind words",
                 mirror.kind_seen[KIND_ADD], mirror.kind_seen[KIND_REMOVE],
                 mirror.kind_seen[KIND_TEST], mirror.kind_seen[KIND_UNUSED]);
        $display("%0d replies checked, %0d adds refused, fill peaked at %0d",
                 mirror.replies_checked, mirror.refused_adds, mirror.peak_fill);
        if (mirror.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
